// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and constants for the min tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int MTS_DEPTH       = 256;
    localparam int MTS_VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming beat
        logic commit;   // apply the latched command and load the result
    } t_dp_cmd;

endpackage

// ===== rtl/core/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencer: accept a beat, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mts_pkg::t_dp_cmd o_dp_cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;
    logic   commit;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_dp_cmd.capture = accept;
    assign o_dp_cmd.commit  = commit;

endmodule

// ===== rtl/core/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath
// value and minimum stores, counts, cached tops and the result register
// ----------------------------------------------------------------------------
module mts_datapath #(
    parameter int DEPTH       = mts_pkg::MTS_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::MTS_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mts_pkg::t_dp_cmd               i_dp_cmd,
    input  mts_pkg::t_cmd                  i_cmd,
    input  logic signed [VALUE_WIDTH-1:0]  i_value,
    output mts_pkg::t_status               o_status,
    output logic signed [VALUE_WIDTH-1:0]  o_popped_value,
    output logic signed [VALUE_WIDTH-1:0]  o_top_value,
    output logic signed [VALUE_WIDTH-1:0]  o_min_value,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic                           o_is_empty
);
    import mts_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    // latched beat
    t_cmd                         r_cmd;
    logic signed [VALUE_WIDTH-1:0] r_value;

    // stack state
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_min_count, n_min_count;
    logic signed [VALUE_WIDTH-1:0] r_top, n_top;
    logic signed [VALUE_WIDTH-1:0] r_min, n_min;

    // result register
    t_status                       r_status;
    logic signed [VALUE_WIDTH-1:0] r_popped, r_o_top, r_o_min;
    logic [CW-1:0]                 r_o_count;
    logic                          r_o_empty;

    t_status                       status;
    logic signed [VALUE_WIDTH-1:0] popped;

    logic                          val_wr_en, min_wr_en;
    logic [AW-1:0]                 val_rd_addr, min_rd_addr;
    logic [VALUE_WIDTH-1:0]        val_rd_data, min_rd_data;

    // entry just below the top, ready in the cycle after the counts settle
    assign val_rd_addr = AW'(r_count - CW'(2));
    assign min_rd_addr = AW'(r_min_count - CW'(2));

    mts_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
        .i_clk    (i_clk),
        .i_wr_en  (val_wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(r_value),
        .i_rd_addr(val_rd_addr),
        .o_rd_data(val_rd_data)
    );

    mts_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_min_ram (
        .i_clk    (i_clk),
        .i_wr_en  (min_wr_en),
        .i_wr_addr(r_min_count[AW-1:0]),
        .i_wr_data(r_value),
        .i_rd_addr(min_rd_addr),
        .o_rd_data(min_rd_data)
    );

    always_comb begin
        n_count     = r_count;
        n_min_count = r_min_count;
        n_top       = r_top;
        n_min       = r_min;
        status      = ST_OK;
        popped      = '0;
        val_wr_en   = 1'b0;
        min_wr_en   = 1'b0;
        case (r_cmd)
            CMD_PUSH: begin
                if (r_count == CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    val_wr_en = i_dp_cmd.commit;
                    n_count   = r_count + CW'(1);
                    n_top     = r_value;
                    // ties go on the min store again
                    if (r_min_count == '0 || r_value <= r_min) begin
                        min_wr_en   = i_dp_cmd.commit;
                        n_min_count = r_min_count + CW'(1);
                        n_min       = r_value;
                    end
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    popped  = r_top;
                    n_count = r_count - CW'(1);
                    n_top   = val_rd_data;
                    if (r_min_count != '0 && r_min == r_top) begin
                        n_min_count = r_min_count - CW'(1);
                        n_min       = min_rd_data;
                    end
                end
            end
            CMD_CLEAR: begin
                n_count     = '0;
                n_min_count = '0;
            end
            CMD_QUERY: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_count <= '0;
        end else if (i_dp_cmd.commit) begin
            r_count     <= n_count;
            r_min_count <= n_min_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (i_dp_cmd.commit) begin
            r_top     <= n_top;
            r_min     <= n_min;
            r_status  <= status;
            r_popped  <= popped;
            r_o_top   <= (n_count != '0) ? n_top : '0;
            r_o_min   <= (n_count != '0 && n_min_count != '0) ? n_min : '0;
            r_o_count <= n_count;
            r_o_empty <= (n_count == '0);
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_top_value    = r_o_top;
    assign o_min_value    = r_o_min;
    assign o_count        = r_o_count;
    assign o_is_empty     = r_o_empty;

endmodule

// ===== rtl/core/min_tracking_stack_unit.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// bounded lifo of signed words that also reports the smallest value held
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | beat contents
//  --------+-----------+---------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_cmd, i_value
//  out     | from block| o_out_valid / i_out_stall | o_status, o_popped_value,
//          |           |                           | o_top_value, o_min_value,
//          |           |                           | o_count, o_is_empty
//
//  every command runs through the accept edge, then an execute edge at
//  which both stores are updated and the result register is loaded; the
//  execute step is there for the registered read port of the stores,
//  which must deliver the entry below the top before a pop can commit
//  the next beat is accepted the cycle after execute, even while the last
//  result is still waiting; execute waits only while that result is stalled
//  reset is synchronous, active low; it empties the stack, no clearing pass
//
module min_tracking_stack_unit #(
    parameter int DEPTH       = mts_pkg::MTS_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::MTS_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mts_pkg::t_cmd                  i_cmd,
    input  logic signed [VALUE_WIDTH-1:0]  i_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mts_pkg::t_status               o_status,
    output logic signed [VALUE_WIDTH-1:0]  o_popped_value,
    output logic signed [VALUE_WIDTH-1:0]  o_top_value,
    output logic signed [VALUE_WIDTH-1:0]  o_min_value,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic                           o_is_empty
);
    import mts_pkg::*;

    // capture and commit strobes from the sequencer
    t_dp_cmd dp_cmd;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_dp_cmd   (dp_cmd)
    );

    // stores, counts, cached top and minimum, result register
    mts_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_popped_value(o_popped_value),
        .o_top_value   (o_top_value),
        .o_min_value   (o_min_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    // one command in flight: an accepted beat blocks the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted while a command executes");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= ($clog2(DEPTH+1))'(DEPTH)))
        else $error("count above depth");

    // empty stack reports zero top and minimum
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_top_value == '0 && o_min_value == '0))
        else $error("empty stack reports nonzero top or minimum");

    // the tracked minimum is never above the top
    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_empty) |-> (o_min_value <= o_top_value))
        else $error("minimum above top of stack");

endmodule

// ===== tb/min_tracking_stack_unit_test.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_unit_test
// self-checking bench for the min tracking stack: a scoreboard predicts every
// result beat from the accepted command beats, and random idling on both
// channels plus one long output hold-off exercise the stall paths
// ----------------------------------------------------------------------------
module min_tracking_stack_unit_test;

    import mts_pkg::*;

    localparam int DEPTH       = MTS_DEPTH;
    localparam int VW          = MTS_VALUE_WIDTH;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 150;   // result beats taken before the long hold-off
    localparam int HOLD_CYCLES = 400;   // length of the long hold-off
    localparam int DRAIN_WAIT  = 8;     // quiet cycles after the last result
    localparam int MAX_REPORTS = 10;

    // one result beat, field by field
    typedef struct {
        t_status              status;
        logic signed [VW-1:0] popped;
        logic signed [VW-1:0] top;
        logic signed [VW-1:0] low;
        logic [CW-1:0]        count;
        logic                 empty;
    } t_stack_result;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of both stores and queues the results
    // ------------------------------------------------------------------------
    class min_stack_scoreboard;
        logic signed [VW-1:0] values [DEPTH];
        logic signed [VW-1:0] minima [DEPTH];
        int unsigned          held;
        int unsigned          min_held;
        t_stack_result        expected_results [$];
        int                   mismatches;

        function new();
            held       = 0;
            min_held   = 0;
            mismatches = 0;
        endfunction

        // predict the result of one accepted command beat
        function void note_command(t_cmd c, logic signed [VW-1:0] v);
            t_stack_result r;
            r.status = ST_OK;
            r.popped = '0;
            case (c)
                CMD_PUSH: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        values[held] = v;
                        held++;
                        // ties go on the minimum store too
                        if (min_held == 0 || v <= minima[min_held-1]) begin
                            if (min_held < DEPTH) begin
                                minima[min_held] = v;
                                min_held++;
                            end
                        end
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        held--;
                        r.popped = values[held];
                        if (min_held > 0 && minima[min_held-1] == r.popped)
                            min_held--;
                    end
                end
                CMD_CLEAR: begin
                    held     = 0;
                    min_held = 0;
                end
                default: begin
                    if (held == 0)
                        r.status = ST_EMPTY;
                end
            endcase
            r.top   = (held > 0) ? values[held-1] : '0;
            r.low   = (held > 0 && min_held > 0) ? minima[min_held-1] : '0;
            r.count = CW'(held);
            r.empty = (held == 0);
            expected_results = {expected_results, r};
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(t_stack_result got);
            t_stack_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d, count %0d",
                             got.status, got.count);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.popped !== want.popped)
                report("popped_value", want.popped, got.popped);
            if (got.top !== want.top)
                report("top_value", want.top, got.top);
            if (got.low !== want.low)
                report("min_value", want.low, got.low);
            if (got.count !== want.count)
                report("count", want.count, got.count);
            if (got.empty !== want.empty)
                report("is_empty", want.empty, got.empty);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_cmd                 i_cmd;
    logic signed [VW-1:0] i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_status              o_status;
    logic signed [VW-1:0] o_popped_value;
    logic signed [VW-1:0] o_top_value;
    logic signed [VW-1:0] o_min_value;
    logic [CW-1:0]        o_count;
    logic                 o_is_empty;

    min_tracking_stack_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_min_value    (o_min_value),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty)
    );

    min_stack_scoreboard book = new();

    // receiver stall is the short per-beat wait or the long hold-off
    logic long_hold   = 1'b0;
    logic short_stall = 1'b0;
    assign i_out_stall = long_hold | short_stall;

    int  results_taken = 0;
    int  cycle_count   = 0;
    bit  sender_burst  = 1'b0;
    bit  sink_burst    = 1'b0;

    // 2 time unit clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: sample at the rising edge, change stall at the falling edge
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int            wait_left;
        t_stack_result got;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.status = o_status;
                got.popped = o_popped_value;
                got.top    = o_top_value;
                got.low    = o_min_value;
                got.count  = o_count;
                got.empty  = o_is_empty;
                book.check_result(got);
                results_taken++;
                // flip now and then between idling and back-to-back beats
                if ($urandom_range(0, 39) == 0)
                    sink_burst = !sink_burst;
                wait_left = sink_burst ? 0 : $urandom_range(0, 7);
            end
            @(negedge i_clk);
            if (wait_left > 0) begin
                short_stall = 1'b1;
                wait_left--;
            end else begin
                short_stall = 1'b0;
            end
        end
    end

    // long hold-off: the sender keeps offering so the block backs up
    initial begin : long_holdoff
        wait (results_taken >= HOLD_AFTER);
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        long_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------

    // one command beat; entered and left just after a falling edge.
    // valid is only lowered when a gap is drawn, so back-to-back beats
    // keep it high without a second assignment in the same step
    task automatic send_beat(input t_cmd c, input logic signed [VW-1:0] v);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = c;
        i_value    = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.note_command(c, v);
        @(negedge i_clk);
    endtask

    // full words half the time, a narrow band so equal minima show up, plus extremes
    function automatic logic signed [VW-1:0] pick_value();
        logic signed [VW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(VW-1){1'b0}}};
                    1:       v = {1'b0, {(VW-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // n random beats with the given command mix in percent, rest are queries
    task automatic random_beats(input int n, input int push_pct, input int pop_pct,
                                input int clear_pct);
        int   r;
        t_cmd c;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                c = CMD_PUSH;
            else if (r < push_pct + pop_pct)
                c = CMD_POP;
            else if (r < push_pct + pop_pct + clear_pct)
                c = CMD_CLEAR;
            else
                c = CMD_QUERY;
            send_beat(c, pick_value());
        end
    endtask

    localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_QUERY;
        i_value    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty errors, extremes, tied minima, clear while loaded
        send_beat(CMD_QUERY, '0);       // query on empty
        send_beat(CMD_POP,   '0);       // pop on empty
        send_beat(CMD_CLEAR, '1);       // clear when already empty
        send_beat(CMD_PUSH,  '0);
        send_beat(CMD_PUSH,  MOST_POS);
        send_beat(CMD_PUSH,  MOST_NEG);
        send_beat(CMD_PUSH,  MOST_NEG); // tie with the minimum
        send_beat(CMD_PUSH,  5);
        send_beat(CMD_QUERY, MOST_POS);
        send_beat(CMD_POP,   '1);
        send_beat(CMD_POP,   '0);       // first copy of the tied minimum
        send_beat(CMD_QUERY, '0);
        send_beat(CMD_POP,   '0);       // second copy
        send_beat(CMD_POP,   '0);
        send_beat(CMD_PUSH,  -1);
        send_beat(CMD_PUSH,  -1);
        send_beat(CMD_PUSH,  3);
        send_beat(CMD_CLEAR, '0);       // clear with values held
        send_beat(CMD_QUERY, '0);
        send_beat(CMD_PUSH,  -7);
        send_beat(CMD_POP,   '0);
        send_beat(CMD_POP,   '0);

        // mixed traffic around the bottom of the stack
        random_beats(150, 45, 30, 5);

        // fill to the brim, then keep pushing against a full stack
        while (book.held < DEPTH)
            random_beats(1, 85, 10, 0);
        random_beats(10, 80, 10, 0);

        // drain to empty, then keep popping
        while (book.held > 0)
            random_beats(1, 10, 85, 0);
        random_beats(5, 0, 70, 0);

        random_beats(60, 45, 30, 5);

        i_in_valid = 1'b0;

        // wait for every predicted result, then a few quiet cycles
        while (book.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (book.mismatches == 0 && book.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
